// File: sv/keyed_batch_former_macros.svh
// assertion macros for the keyed batch former checker
// expects clk_i and rst_ni to be visible where a macro is used
`ifndef KEYED_BATCH_FORMER_MACROS_SVH
`define KEYED_BATCH_FORMER_MACROS_SVH

// same-cycle implication
`define KBF_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define KBF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/kbf_pkg.sv
// shared types and constants of the keyed batch former
// no dependencies; used by keyed_batch_former, kbf_checker and the testbench
package kbf_pkg;

  // small counts: batch size, members gathered, results per item
  typedef logic [4:0] cnt_t;
  typedef logic [5:0] sum_t;

  localparam cnt_t MinBatch   = 5'd2;
  localparam cnt_t MaxBatch   = 5'd16;
  localparam sum_t MaxResults = 6'd16;

  // register indexes of the configuration port
  localparam logic RegBatchSize = 1'b0;
  localparam logic RegBatchRule = 1'b1;

  // batch rule codes
  localparam logic [1:0] RuleAny      = 2'd0;
  localparam logic [1:0] RuleSameKey  = 2'd1;
  localparam logic [1:0] RuleDistinct = 2'd2;

  typedef struct packed {
    logic [15:0] entry_id;
    logic [15:0] entry_key;
    logic [31:0] created_at;
  } in_item_t;

  typedef struct packed {
    logic [15:0] member_id;
    logic [15:0] member_key;
    logic [31:0] batch_created_at;
    logic        last_member;
    logic        refused;
  } out_item_t;

endpackage

// File: sv/keyed_batch_former.sv
// Each store pass reads the entries in turn through one read port with registered read data.
// Rule any: append, one min pass and one emit/compact pass.
// Same key and distinct: an outer cursor with an inner scan.
// One item at a time; in_ready_o is high only while the sequencer is idle.
// Reset (async, active low) empties the store count and loads batch_size 2, rule 0;
// the store itself is not cleared, entries at or above the count are never read.
module keyed_batch_former #(
  parameter int unsigned STORE_DEPTH = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  kbf_pkg::in_item_t    in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output kbf_pkg::out_item_t   out_item_o,
  input  logic                 cfg_we_i,
  input  logic                 cfg_idx_i,
  input  logic [4:0]           cfg_data_i
);

  localparam int unsigned AW = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(STORE_DEPTH + 1);

  typedef logic [AW-1:0] idx_t;
  typedef logic [CW-1:0] ptr_t;

  // sequencer codes
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_REFUSE  = 5'd1;
  localparam logic [4:0] S_TRY     = 5'd2;
  localparam logic [4:0] S_R1_KEY  = 5'd3;
  localparam logic [4:0] S_R1_KW   = 5'd4;
  localparam logic [4:0] S_R1_RD   = 5'd5;
  localparam logic [4:0] S_R1_CMP  = 5'd6;
  localparam logic [4:0] S_R2_KEY  = 5'd7;
  localparam logic [4:0] S_R2_KW   = 5'd8;
  localparam logic [4:0] S_R2_RD   = 5'd9;
  localparam logic [4:0] S_R2_CMP  = 5'd10;
  localparam logic [4:0] S_MIN0    = 5'd11;
  localparam logic [4:0] S_MIN_RD  = 5'd12;
  localparam logic [4:0] S_MIN_CMP = 5'd13;
  localparam logic [4:0] S_EM0     = 5'd14;
  localparam logic [4:0] S_EM_RD   = 5'd15;
  localparam logic [4:0] S_EM_DO   = 5'd16;

  // waiting store, one write and one registered read port
  kbf_pkg::in_item_t store_mem [STORE_DEPTH];
  kbf_pkg::in_item_t rd_q;
  logic              rd_en;
  idx_t              rd_addr;
  logic              wr_en;
  idx_t              wr_addr;
  kbf_pkg::in_item_t wr_data;

  logic [4:0]            state_q, state_d;
  ptr_t                  count_q, count_d;
  ptr_t                  i_q, i_d;
  ptr_t                  j_q, j_d;
  ptr_t                  w_q, w_d;
  kbf_pkg::cnt_t         got_q, got_d;
  kbf_pkg::cnt_t         left_q, left_d;
  kbf_pkg::cnt_t         n_q, n_d;
  logic [STORE_DEPTH-1:0] pick_q, pick_d;
  logic [15:0]           key_q, key_d;
  logic [31:0]           oldest_q, oldest_d;
  kbf_pkg::in_item_t     hold_q, hold_d;
  logic                  out_valid_q, out_valid_d;
  kbf_pkg::out_item_t    out_q, out_d;
  logic [4:0]            batch_size_q;
  logic [1:0]            batch_rule_q;

  kbf_pkg::cnt_t size;
  kbf_pkg::sum_t res_sum;
  logic          out_free;
  logic          key_hit;

  // clamp the batch size into its meaningful range
  always_comb begin
    if (batch_size_q < kbf_pkg::MinBatch) begin
      size = kbf_pkg::MinBatch;
    end else if (batch_size_q > kbf_pkg::MaxBatch) begin
      size = kbf_pkg::MaxBatch;
    end else begin
      size = batch_size_q;
    end
  end

  assign res_sum  = kbf_pkg::sum_t'(n_q) + kbf_pkg::sum_t'(size);
  assign out_free = !out_valid_q || out_ready_i;
  // shared key comparator
  assign key_hit  = (rd_q.entry_key == key_q);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // sequencer
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    i_d         = i_q;
    j_d         = j_q;
    w_d         = w_q;
    got_d       = got_q;
    left_d      = left_q;
    n_d         = n_q;
    pick_d      = pick_q;
    key_d       = key_q;
    oldest_d    = oldest_q;
    hold_d      = hold_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = count_q[AW-1:0];
    wr_data     = in_item_i;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          hold_d = in_item_i;
          if (count_q == ptr_t'(STORE_DEPTH)) begin
            state_d = S_REFUSE;
          end else begin
            wr_en   = 1'b1;
            count_d = count_q + ptr_t'(1);
            n_d     = '0;
            state_d = S_TRY;
          end
        end
      end

      // echo the dropped item with the refused flag
      S_REFUSE: begin
        if (out_free) begin
          out_valid_d          = 1'b1;
          out_d.member_id        = hold_q.entry_id;
          out_d.member_key       = hold_q.entry_key;
          out_d.batch_created_at = hold_q.created_at;
          out_d.last_member      = 1'b0;
          out_d.refused          = 1'b1;
          state_d              = S_IDLE;
        end
      end

      // start one batch attempt if another whole batch still fits
      S_TRY: begin
        i_d   = '0;
        got_d = '0;
        if (res_sum > kbf_pkg::MaxResults) begin
          state_d = S_IDLE;
        end else begin
          unique case (batch_rule_q)
            kbf_pkg::RuleAny: begin
              if (32'(count_q) >= 32'(size)) begin
                for (int k = 0; k < STORE_DEPTH; k++) begin
                  pick_d[k] = (32'(k) < 32'(size));
                end
                got_d   = size;
                state_d = S_MIN0;
              end else begin
                state_d = S_IDLE;
              end
            end
            kbf_pkg::RuleSameKey: begin
              state_d = S_R1_KEY;
            end
            kbf_pkg::RuleDistinct: begin
              pick_d  = '0;
              state_d = S_R2_KEY;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      // same key: candidate key at cursor i, count matches from i on
      S_R1_KEY: begin
        if (i_q == count_q) begin
          state_d = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = i_q[AW-1:0];
          pick_d  = '0;
          got_d   = '0;
          j_d     = i_q;
          state_d = S_R1_KW;
        end
      end

      S_R1_KW: begin
        key_d   = rd_q.entry_key;
        state_d = S_R1_RD;
      end

      S_R1_RD: begin
        if (got_q == size) begin
          state_d = S_MIN0;
        end else if (j_q == count_q) begin
          i_d     = i_q + ptr_t'(1);
          state_d = S_R1_KEY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = j_q[AW-1:0];
          state_d = S_R1_CMP;
        end
      end

      S_R1_CMP: begin
        if (key_hit) begin
          pick_d[j_q[AW-1:0]] = 1'b1;
          got_d               = got_q + kbf_pkg::cnt_t'(1);
        end
        j_d     = j_q + ptr_t'(1);
        state_d = S_R1_RD;
      end

      // distinct: take entry i unless an earlier pick has its key
      S_R2_KEY: begin
        if (got_q == size) begin
          state_d = S_MIN0;
        end else if (i_q == count_q) begin
          state_d = S_IDLE;
        end else begin
          rd_en   = 1'b1;
          rd_addr = i_q[AW-1:0];
          state_d = S_R2_KW;
        end
      end

      S_R2_KW: begin
        key_d   = rd_q.entry_key;
        j_d     = '0;
        state_d = S_R2_RD;
      end

      S_R2_RD: begin
        if (j_q == i_q) begin
          pick_d[i_q[AW-1:0]] = 1'b1;
          got_d               = got_q + kbf_pkg::cnt_t'(1);
          i_d                 = i_q + ptr_t'(1);
          state_d             = S_R2_KEY;
        end else if (!pick_q[j_q[AW-1:0]]) begin
          j_d = j_q + ptr_t'(1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = j_q[AW-1:0];
          state_d = S_R2_CMP;
        end
      end

      S_R2_CMP: begin
        if (key_hit) begin
          i_d     = i_q + ptr_t'(1);
          state_d = S_R2_KEY;
        end else begin
          j_d     = j_q + ptr_t'(1);
          state_d = S_R2_RD;
        end
      end

      // oldest creation time over the picked entries
      S_MIN0: begin
        oldest_d = '1;
        j_d      = '0;
        state_d  = S_MIN_RD;
      end

      S_MIN_RD: begin
        if (j_q == count_q) begin
          state_d = S_EM0;
        end else if (!pick_q[j_q[AW-1:0]]) begin
          j_d = j_q + ptr_t'(1);
        end else begin
          rd_en   = 1'b1;
          rd_addr = j_q[AW-1:0];
          state_d = S_MIN_CMP;
        end
      end

      S_MIN_CMP: begin
        if (rd_q.created_at < oldest_q) begin
          oldest_d = rd_q.created_at;
        end
        j_d     = j_q + ptr_t'(1);
        state_d = S_MIN_RD;
      end

      // emit picked entries and compact the rest in one pass
      S_EM0: begin
        j_d     = '0;
        w_d     = '0;
        left_d  = got_q;
        state_d = S_EM_RD;
      end

      S_EM_RD: begin
        if (j_q == count_q) begin
          count_d = w_q;
          state_d = S_TRY;
        end else begin
          rd_en   = 1'b1;
          rd_addr = j_q[AW-1:0];
          state_d = S_EM_DO;
        end
      end

      S_EM_DO: begin
        if (pick_q[j_q[AW-1:0]]) begin
          if (out_free) begin
            out_valid_d            = 1'b1;
            out_d.member_id        = rd_q.entry_id;
            out_d.member_key       = rd_q.entry_key;
            out_d.batch_created_at = oldest_q;
            out_d.last_member      = (left_q == kbf_pkg::cnt_t'(1));
            out_d.refused          = 1'b0;
            left_d                 = left_q - kbf_pkg::cnt_t'(1);
            n_d                    = n_q + kbf_pkg::cnt_t'(1);
            j_d                    = j_q + ptr_t'(1);
            state_d                = S_EM_RD;
          end
        end else begin
          wr_en   = 1'b1;
          wr_addr = w_q[AW-1:0];
          wr_data = rd_q;
          w_d     = w_q + ptr_t'(1);
          j_d     = j_q + ptr_t'(1);
          state_d = S_EM_RD;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // store access
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= store_mem[rd_addr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    out_q    <= out_d;
    hold_q   <= hold_d;
    key_q    <= key_d;
    oldest_q <= oldest_d;
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      i_q         <= '0;
      j_q         <= '0;
      w_q         <= '0;
      got_q       <= '0;
      left_q      <= '0;
      n_q         <= '0;
      pick_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      i_q         <= i_d;
      j_q         <= j_d;
      w_q         <= w_d;
      got_q       <= got_d;
      left_q      <= left_d;
      n_q         <= n_d;
      pick_q      <= pick_d;
      out_valid_q <= out_valid_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      batch_size_q <= 5'd2;
      batch_rule_q <= kbf_pkg::RuleAny;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        kbf_pkg::RegBatchSize: batch_size_q <= cfg_data_i;
        kbf_pkg::RegBatchRule: batch_rule_q <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/kbf_checker.sv
// port-level checks of the keyed batch former, bound into keyed_batch_former
// depends on kbf_pkg and keyed_batch_former_macros.svh
`include "keyed_batch_former_macros.svh"

module kbf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_ready_o,
  input logic               out_valid_o,
  input logic               out_ready_i,
  input kbf_pkg::out_item_t out_item_o
);

  // a result item stays offered until taken
  `KBF_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, "out item dropped")

  // a stalled result item keeps its payload
  `KBF_ASSERT_NEXT(a_out_stable, out_valid_o && !out_ready_i, $stable(out_item_o), "out item changed")

  // a refusal never closes a batch
  `KBF_ASSERT_NOW(a_refuse_flags, out_valid_o && out_item_o.refused, !out_item_o.last_member, "refused item marked last")

  // the sequencer is busy right after an accepted item
  `KBF_ASSERT_NEXT(a_busy_after_in, in_valid_i && in_ready_o, !in_ready_o, "ready right after accept")

endmodule

bind keyed_batch_former kbf_checker u_kbf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_item_o  (out_item_o)
);

// File: tb/testbench.sv
// self-checking testbench for keyed_batch_former: random bursts of arrivals under every batch rule
// keeps its own model of the waiting store; depends on kbf_pkg and keyed_batch_former
`timescale 1ns / 1ps

module testbench;

  localparam int StoreDepth = 16;
  // settle margin sized for the worst store pass under same key / distinct
  localparam int SettleCycles = 2 * StoreDepth * StoreDepth + 88;
  localparam logic [1:0] RuleUnused = 2'd3;

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  kbf_pkg::in_item_t    in_item_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  kbf_pkg::out_item_t   out_item_o;
  logic                 cfg_we_i = 1'b0;
  logic                 cfg_idx_i = kbf_pkg::RegBatchSize;
  logic [4:0]           cfg_data_i = '0;

  keyed_batch_former #(
    .STORE_DEPTH(StoreDepth)
  ) dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_item_i(in_item_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_item_o(out_item_o),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i)
  );

  // arrivals waiting to be driven, and members expected back
  kbf_pkg::in_item_t  arrival_q[$];
  kbf_pkg::out_item_t member_q[$];

  // shadow of the block: waiting store and registers
  kbf_pkg::in_item_t held_q[$];
  logic [4:0] cur_size = kbf_pkg::MinBatch;
  logic [1:0] cur_rule = kbf_pkg::RuleAny;

  int queued_cnt = 0;
  int accepted_cnt = 0;
  int member_cnt = 0;
  int batch_cnt = 0;
  int refusal_cnt = 0;
  int mismatch_cnt = 0;
  logic in_taken = 1'b0;
  logic [15:0] key_pool[8];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // marks the members of the next batch; returns their number or 0
  function automatic int choose_members(input int need, output logic [StoreDepth-1:0] chosen);
    int got;
    int hits;
    logic seen;
    chosen = '0;
    got = 0;
    case (cur_rule)
      kbf_pkg::RuleAny: begin
        if (held_q.size() >= need) begin
          for (int i = 0; i < need; i++) chosen[i] = 1'b1;
          got = need;
        end
      end
      kbf_pkg::RuleSameKey: begin
        for (int i = 0; i < held_q.size() && got == 0; i++) begin
          hits = 0;
          for (int j = i; j < held_q.size(); j++)
            if (held_q[j].entry_key == held_q[i].entry_key) hits++;
          if (hits >= need) begin
            for (int j = i; j < held_q.size() && got < need; j++) begin
              if (held_q[j].entry_key == held_q[i].entry_key) begin
                chosen[j] = 1'b1;
                got++;
              end
            end
          end
        end
      end
      kbf_pkg::RuleDistinct: begin
        for (int i = 0; i < held_q.size() && got < need; i++) begin
          seen = 1'b0;
          for (int j = 0; j < i; j++)
            if (chosen[j] && held_q[j].entry_key == held_q[i].entry_key) seen = 1'b1;
          if (!seen) begin
            chosen[i] = 1'b1;
            got++;
          end
        end
        if (got < need) begin
          chosen = '0;
          got = 0;
        end
      end
      default: ;
    endcase
    return got;
  endfunction

  // appends one arrival (or queues its refusal when the store is full) and queues every member it releases
  function automatic void predict_arrival(input kbf_pkg::in_item_t it);
    int need;
    int emitted;
    int got;
    int left;
    logic [StoreDepth-1:0] chosen;
    logic [31:0] oldest;
    kbf_pkg::out_item_t res;
    kbf_pkg::in_item_t kept[$];
    // full store: the arrival comes straight back refused
    if (held_q.size() >= StoreDepth) begin
      res.member_id = it.entry_id;
      res.member_key = it.entry_key;
      res.batch_created_at = it.created_at;
      res.last_member = 1'b0;
      res.refused = 1'b1;
      member_q.insert(member_q.size(), res);
      return;
    end
    held_q.insert(held_q.size(), it);
    need = int'((cur_size < kbf_pkg::MinBatch) ? kbf_pkg::MinBatch :
                (cur_size > kbf_pkg::MaxBatch) ? kbf_pkg::MaxBatch : cur_size);
    emitted = 0;
    while (emitted + need <= int'(kbf_pkg::MaxResults)) begin
      got = choose_members(need, chosen);
      if (got == 0) break;
      oldest = '1;
      for (int i = 0; i < held_q.size(); i++)
        if (chosen[i] && held_q[i].created_at < oldest) oldest = held_q[i].created_at;
      left = got;
      kept = {};
      for (int i = 0; i < held_q.size(); i++) begin
        if (chosen[i]) begin
          left--;
          res.member_id = held_q[i].entry_id;
          res.member_key = held_q[i].entry_key;
          res.batch_created_at = oldest;
          res.last_member = (left == 0);
          res.refused = 1'b0;
          member_q.insert(member_q.size(), res);
        end else begin
          kept.insert(kept.size(), held_q[i]);
        end
      end
      held_q = kept;
      emitted += got;
    end
  endfunction

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  // monitor: registers, accepted arrivals and emitted members at the rising edge
  always @(posedge clk_i) begin
    kbf_pkg::out_item_t want;
    in_taken = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == kbf_pkg::RegBatchSize) cur_size = cfg_data_i;
        else cur_rule = cfg_data_i[1:0];
      end
      if (in_taken) begin
        predict_arrival(in_item_i);
        accepted_cnt++;
      end
      if (out_valid_o && out_ready_i) begin
        member_cnt++;
        if (out_item_o.last_member === 1'b1) batch_cnt++;
        if (out_item_o.refused === 1'b1) refusal_cnt++;
        if (member_q.size() == 0) begin
          $display("%0t ns: unexpected item, expected none, actual %p", $time, out_item_o);
          mismatch_cnt++;
        end else begin
          want = member_q.pop_front();
          check_field("member_id", 32'(want.member_id), 32'(out_item_o.member_id));
          check_field("member_key", 32'(want.member_key), 32'(out_item_o.member_key));
          check_field("batch_created_at", want.batch_created_at,
                      out_item_o.batch_created_at);
          check_field("last_member", 32'(want.last_member), 32'(out_item_o.last_member));
          check_field("refused", 32'(want.refused), 32'(out_item_o.refused));
        end
      end
    end
  end

  // driver: bursts of arrivals with random gaps in between
  int burst_left = 1;
  int gap_left = 0;
  always @(negedge clk_i) begin
    if (!in_valid_i || in_taken) begin
      if (gap_left != 0) begin
        gap_left <= gap_left - 1;
        in_valid_i <= 1'b0;
      end else if (arrival_q.size() != 0) begin
        in_item_i <= arrival_q.pop_front();
        in_valid_i <= 1'b1;
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 20);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver: rotating stall pattern, reloaded with a new random pattern
  int ready_step = 0;
  logic [15:0] ready_pattern = 16'hffff;
  always @(negedge clk_i) begin
    out_ready_i <= ready_pattern[ready_step % 16];
    ready_step++;
    if (ready_step % 64 == 0) begin
      case ($urandom_range(0, 3))
        0: ready_pattern = 16'hffff;
        1: ready_pattern = 16'($urandom & $urandom);
        default: ready_pattern = 16'($urandom);
      endcase
    end
  end

  task automatic write_reg(input logic idx, input logic [4:0] value);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic push_item(input logic [15:0] id, input logic [15:0] key, input logic [31:0] t);
    kbf_pkg::in_item_t it;
    it.entry_id = id;
    it.entry_key = key;
    it.created_at = t;
    arrival_q.insert(arrival_q.size(), it);
    queued_cnt++;
  endtask

  // hold off until every arrival is taken and every member is back, then let the block finish
  task automatic settle();
    while (accepted_cnt != queued_cnt || member_q.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  function automatic logic [15:0] draw_key(input int pool_n);
    if (pool_n == 0 || $urandom_range(0, 7) == 0) return 16'($urandom);
    return key_pool[$urandom_range(0, pool_n - 1)];
  endfunction

  task automatic push_random(input int count, input int pool_n);
    for (int i = 0; i < count; i++)
      push_item(16'($urandom_range(0, 65535)), draw_key(pool_n), $urandom);
  endtask

  task automatic fill_pool();
    for (int i = 0; i < 8; i++) key_pool[i] = 16'($urandom);
  endtask

  // stimulus
  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: pairs in arrival order, field extremes
    push_item(16'h0000, 16'h0000, 32'hffffffff);
    push_item(16'hffff, 16'hffff, 32'h00000000);
    push_item(16'h1234, 16'h0000, 32'h00000005);
    push_item(16'hffff, 16'h0001, 32'hffffffff);
    settle();

    // same key, three per batch, keys interleaved
    write_reg(kbf_pkg::RegBatchSize, 5'd3);
    write_reg(kbf_pkg::RegBatchRule, {3'b000, kbf_pkg::RuleSameKey});
    push_item(16'd10, 16'd5, 32'd700);
    push_item(16'd11, 16'd9, 32'd300);
    push_item(16'd12, 16'd5, 32'd100);
    push_item(16'd13, 16'd9, 32'd900);
    push_item(16'd14, 16'd5, 32'd200);
    push_item(16'd15, 16'd9, 32'd50);
    settle();

    // one of each distinct key, duplicates left behind
    write_reg(kbf_pkg::RegBatchRule, {3'b000, kbf_pkg::RuleDistinct});
    push_item(16'd20, 16'd1, 32'd40);
    push_item(16'd21, 16'd1, 32'd30);
    push_item(16'd22, 16'd2, 32'd20);
    push_item(16'd23, 16'd1, 32'd10);
    push_item(16'd24, 16'd3, 32'd60);
    settle();

    // unused rule only accumulates; then several batches from one arrival
    write_reg(kbf_pkg::RegBatchRule, {3'b000, RuleUnused});
    push_random(7, 0);
    settle();
    write_reg(kbf_pkg::RegBatchSize, 5'd0);
    write_reg(kbf_pkg::RegBatchRule, {3'b000, kbf_pkg::RuleAny});
    push_random(1, 0);
    settle();

    // random phases, one per rule, results drained between them
    write_reg(kbf_pkg::RegBatchSize, 5'($urandom_range(2, 5)));
    push_random(12, 0);
    settle();

    fill_pool();
    write_reg(kbf_pkg::RegBatchSize, 5'($urandom_range(2, 4)));
    write_reg(kbf_pkg::RegBatchRule, {3'b000, kbf_pkg::RuleSameKey});
    push_random(12, 3);
    settle();

    fill_pool();
    write_reg(kbf_pkg::RegBatchSize, 5'($urandom_range(2, 5)));
    write_reg(kbf_pkg::RegBatchRule, {3'b000, kbf_pkg::RuleDistinct});
    push_random(12, 7);
    settle();

    // oversized setting clamps to full batches of sixteen
    write_reg(kbf_pkg::RegBatchSize, 5'd31);
    write_reg(kbf_pkg::RegBatchRule, {3'b000, kbf_pkg::RuleAny});
    push_random(32, 0);
    settle();

    // fill the store under the unused rule, then arrivals are refused
    write_reg(kbf_pkg::RegBatchRule, {3'b000, RuleUnused});
    push_random(16, 0);
    push_item(16'h0000, 16'h0000, 32'h00000000);
    push_item(16'hffff, 16'hffff, 32'hffffffff);
    push_item(16'h5a5a, 16'ha5a5, 32'h80000001);
    push_item(16'ha5a5, 16'h5a5a, 32'h7ffffffe);
    settle();

    $display("%0d arrivals under rules any, same key, distinct and unused", accepted_cnt);
    $display("%0d members in %0d batches, %0d refusals", member_cnt - refusal_cnt, batch_cnt,
             refusal_cnt);
    if (member_q.size() != 0) begin
      $display("%0t ns: %0d expected items never arrived", $time, member_q.size());
    end
    if (mismatch_cnt == 0 && member_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #12_000_000;
    $display("%0t ns: timeout", $time);
    $display("Simulation FAILED");
    $finish;
  end

endmodule
